@@ design/timecode_pulse_bit_receiver_assert.svh @@
// Assertion macros used by the time-code receiver top level.
`ifndef TIMECODE_PULSE_BIT_RECEIVER_ASSERT_SVH
`define TIMECODE_PULSE_BIT_RECEIVER_ASSERT_SVH

`ifndef SYNTHESIS

`define TPBR_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

`define TPBR_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`define TPBR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define TPBR_ASSERT_ALWAYS(label, clk, rstn, cond, msg)
`define TPBR_ASSERT_SAME(label, clk, rstn, ante, cons, msg)
`define TPBR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

@@ design/tpbr_pkg.sv @@
// Types, constants and register codes of the time-code pulse bit receiver.
`default_nettype none

package tpbr_pkg;

    // Number of bit positions in a collected frame (64).
    localparam int FRAME_WIDTH = 64;
    localparam logic [6:0] FRAME_LIMIT = 7'(FRAME_WIDTH);
    localparam logic [6:0] IDX_CAP_COUNT = 7'd63;
    localparam logic [5:0] IDX_CAP = 6'd63;

    // Configuration register indexes.
    localparam logic [2:0] REG_MIN_OFF       = 3'd0;
    localparam logic [2:0] REG_MIN_GAP       = 3'd1;
    localparam logic [2:0] REG_MINUTE_GAP    = 3'd2;
    localparam logic [2:0] REG_MIN_PULSE     = 3'd3;
    localparam logic [2:0] REG_ONE_THRESHOLD = 3'd4;
    localparam logic [2:0] REG_MIN_FRAME     = 3'd5;

    // Register reset values.
    localparam logic [15:0] RST_MIN_OFF_MS       = 16'd30;
    localparam logic [15:0] RST_MIN_GAP_MS       = 16'd900;
    localparam logic [15:0] RST_MINUTE_GAP_MS    = 16'd1500;
    localparam logic [15:0] RST_MIN_PULSE_MS     = 16'd70;
    localparam logic [15:0] RST_ONE_THRESHOLD_MS = 16'd150;
    localparam logic [6:0]  RST_MIN_FRAME_BITS   = 7'd59;

    // Result kinds.
    localparam logic EV_BIT   = 1'b0;
    localparam logic EV_FRAME = 1'b1;

    typedef struct packed {
        logic [15:0] min_off_ms;
        logic [15:0] min_gap_ms;
        logic [15:0] minute_gap_ms;
        logic [15:0] min_pulse_ms;
        logic [15:0] one_threshold_ms;
        logic [6:0]  min_frame_bits;
    } tpbr_cfg_t;

    typedef struct packed {
        logic        active;
        logic        armed;
        logic [31:0] start_time;
        logic [31:0] last_high;
        logic [6:0]  bit_count;
        logic [63:0] frame;
    } tpbr_state_t;

    typedef struct packed {
        logic [31:0] time_ms;
        logic        level;
    } tpbr_in_t;

    typedef struct packed {
        logic        event_res;
        logic        bit_value;
        logic [5:0]  bit_index;
        logic [31:0] pulse_ms;
        logic [63:0] frame_bits;
        logic [6:0]  frame_count;
        logic        frame_valid;
    } tpbr_out_t;

    typedef struct packed {
        logic      valid;
        tpbr_out_t word;
    } tpbr_res_t;

endpackage

`default_nettype wire

@@ design/tpbr_decode.sv @@
// Per-sample edge tracking, bit decode and frame bookkeeping.
`default_nettype none

module tpbr_decode
    import tpbr_pkg::*;
(
    input  tpbr_cfg_t   cfg,
    input  tpbr_state_t cur,
    input  tpbr_in_t    sample,
    output tpbr_state_t nxt,
    output tpbr_res_t   res
);

    logic [31:0] gap;
    logic [31:0] off_time;
    logic [31:0] plen;
    logic        rise;
    logic        fall;
    logic        off_long;
    logic        one_bit;

    assign gap      = sample.time_ms - cur.start_time;
    assign off_time = sample.time_ms - cur.last_high;
    assign plen     = sample.time_ms - cur.start_time;
    assign rise     = !cur.active && sample.level;
    assign fall     = cur.active && !sample.level;
    // A negative off time, read as signed, never counts as long enough.
    assign off_long = !off_time[31] && (off_time > {16'd0, cfg.min_off_ms});
    assign one_bit  = plen > {16'd0, cfg.one_threshold_ms};

    always_comb begin
        nxt = cur;
        res = '0;
        if (sample.level) begin
            nxt.last_high = sample.time_ms;
        end
        if (rise) begin
            if (!cur.armed) begin
                // A time stamp of zero keeps the receiver unarmed.
                nxt.armed = (sample.time_ms != 32'd0);
            end else if (gap > {16'd0, cfg.min_gap_ms}) begin
                if (gap > {16'd0, cfg.minute_gap_ms}) begin
                    res.valid            = 1'b1;
                    res.word.event_res   = EV_FRAME;
                    res.word.frame_bits  = cur.frame;
                    res.word.frame_count = cur.bit_count;
                    res.word.frame_valid = (cur.bit_count >= cfg.min_frame_bits);
                    nxt.frame            = '0;
                    nxt.bit_count        = '0;
                end
                nxt.start_time = sample.time_ms;
                nxt.active     = 1'b1;
            end
        end else if (fall && off_long && (plen > {16'd0, cfg.min_pulse_ms})) begin
            if (cur.bit_count < FRAME_LIMIT) begin
                nxt.frame     = cur.frame | (64'(one_bit) << cur.bit_count[5:0]);
                nxt.bit_count = cur.bit_count + 7'd1;
            end
            res.valid            = 1'b1;
            res.word.event_res   = EV_BIT;
            res.word.bit_value   = one_bit;
            res.word.bit_index   = (cur.bit_count > IDX_CAP_COUNT) ? IDX_CAP
                                                                   : cur.bit_count[5:0];
            res.word.pulse_ms    = plen;
            res.word.frame_bits  = nxt.frame;
            res.word.frame_count = nxt.bit_count;
            nxt.active           = 1'b0;
            nxt.last_high        = sample.time_ms;
        end
    end

endmodule

`default_nettype wire

@@ design/timecode_pulse_bit_receiver.sv @@
// Top level of the pulse-width time-code bit receiver.
//
// One input word per antenna sample: a wrapping millisecond time stamp and the
// pulse level. Each accepted sample yields zero or one result word: a decoded
// data bit with its index and pulse length, or a minute-frame report carrying
// the collected 64-bit frame, its bit count and a validity flag.
// Samples are registered on s_valid/s_ready, decoded by the edge and frame
// logic against the receiver state, and a resulting word is loaded into the
// output register as the decode stage advances. One sample per cycle is
// sustained while the output is not stalled; the single state update per
// cycle in the decode stage sets that rate. When m_ready is low with a word
// waiting, the decode stage holds its sample and s_ready drops once that stage
// is full; samples without a result still drain whenever the output slot can
// take a word. Thresholds are written through cfg_wr_en/cfg_index/cfg_wdata;
// the user must write them only while the block is idle, which the block does
// not enforce. A synchronous low aresetn restores the default thresholds,
// disarms the receiver and clears the frame; no clearing pass is needed.
`default_nettype none
`include "timecode_pulse_bit_receiver_assert.svh"

module timecode_pulse_bit_receiver
    import tpbr_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_wr_en,
    input  wire  [2:0]  cfg_index,
    input  wire  [15:0] cfg_wdata,
    input  wire         s_valid,
    output logic        s_ready,
    input  tpbr_in_t    s_data,
    output logic        m_valid,
    input  wire         m_ready,
    output tpbr_out_t   m_data
);

    tpbr_cfg_t   cfg_reg;
    tpbr_state_t st_reg;
    tpbr_state_t st_next;
    tpbr_res_t   dec_res;
    tpbr_in_t    in_reg;
    logic        in_valid_reg;
    tpbr_out_t   out_reg;
    logic        out_valid_reg;
    logic        out_free;
    logic        advance;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || advance;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    tpbr_decode u_decode (
        .cfg    (cfg_reg),
        .cur    (st_reg),
        .sample (in_reg),
        .nxt    (st_next),
        .res    (dec_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_off_ms       <= RST_MIN_OFF_MS;
            cfg_reg.min_gap_ms       <= RST_MIN_GAP_MS;
            cfg_reg.minute_gap_ms    <= RST_MINUTE_GAP_MS;
            cfg_reg.min_pulse_ms     <= RST_MIN_PULSE_MS;
            cfg_reg.one_threshold_ms <= RST_ONE_THRESHOLD_MS;
            cfg_reg.min_frame_bits   <= RST_MIN_FRAME_BITS;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MIN_OFF:       cfg_reg.min_off_ms       <= cfg_wdata;
                REG_MIN_GAP:       cfg_reg.min_gap_ms       <= cfg_wdata;
                REG_MINUTE_GAP:    cfg_reg.minute_gap_ms    <= cfg_wdata;
                REG_MIN_PULSE:     cfg_reg.min_pulse_ms     <= cfg_wdata;
                REG_ONE_THRESHOLD: cfg_reg.one_threshold_ms <= cfg_wdata;
                REG_MIN_FRAME:     cfg_reg.min_frame_bits   <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                st_reg <= st_next;
            end
            if (advance && dec_res.valid) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance && dec_res.valid) begin
            out_reg <= dec_res.word;
        end
    end

    `TPBR_ASSERT_ALWAYS(a_count_limit, aclk, aresetn, st_reg.bit_count <= FRAME_LIMIT, "bit count beyond frame width")
    `TPBR_ASSERT_SAME(a_active_armed, aclk, aresetn, st_reg.active, st_reg.armed, "pulse tracked while unarmed")
    `TPBR_ASSERT_SAME(a_stall_holds, aclk, aresetn, out_valid_reg && !m_ready, !advance, "decode advanced into a stalled output")
    `TPBR_ASSERT_NEXT(a_frame_clears, aclk, aresetn, advance && dec_res.valid && dec_res.word.event_res == EV_FRAME, st_reg.bit_count == 7'd0 && st_reg.frame == 64'd0, "frame not cleared after minute report")

endmodule

`default_nettype wire
